/* rtl/gn2_pkg.sv */
// ----------------------------------------------------------------------------
// gn2_pkg
// Shared types, constants and table functions of the 2D gradient noise block.
// ----------------------------------------------------------------------------
package gn2_pkg;

   localparam int DEF_TABLE_SIZE      = 2048;
   localparam int DEF_COORD_FRAC_BITS = 16;
   localparam int GRAD_COUNT          = 24;

   localparam int COORD_W   = 32;
   localparam int NOISE_W   = 16;
   localparam int SEED_W    = 64;
   localparam int GRAD_W    = 5;
   localparam int PERM_MAXW = 12;
   localparam int FRAC      = 24;
   localparam int MUL_W     = 32;
   localparam int PROD_W    = 64;
   localparam int D_W       = 28;
   localparam int GV_W      = 25;
   localparam int OUT_SHIFT = 34;

   localparam logic signed [MUL_W-1:0]  SKEW_Q     = 32'sd6140887;
   localparam logic signed [MUL_W-1:0]  UNSKEW_Q   = 32'sd3545443;
   localparam logic signed [MUL_W-1:0]  RSQ_Q      = 32'sd11184811;
   localparam logic signed [MUL_W-1:0]  SCALE_Q    = 32'sd306049336;
   localparam logic signed [PROD_W-1:0] ROUND_BIAS = 64'sh0000_0002_0000_0000;
   localparam logic signed [PROD_W-1:0] SAT_HI     = 64'sd32767;
   localparam logic signed [PROD_W-1:0] SAT_LO     = -64'sd32768;

   localparam logic [SEED_W-1:0] GOLDEN = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [SEED_W-1:0] MIX_C1 = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [SEED_W-1:0] MIX_C2 = 64'h94d0_49bb_1331_11eb;

   typedef enum logic {
      OP_REBUILD  = 1'b0,
      OP_EVALUATE = 1'b1
   } opcode_type;

   typedef struct packed {
      logic idle;
      logic done;
   } eng_stat_type;

   typedef struct packed {
      logic signed [GV_W-1:0] gx;
      logic signed [GV_W-1:0] gz;
   } grad_type;

   typedef struct packed {
      logic signed [2:0]     cdx;
      logic signed [2:0]     cdz;
      logic signed [D_W-1:0] odx;
      logic signed [D_W-1:0] odz;
   } vtx_off_type;

   // Permutation value modulo 24, as (p / 8 mod 3) * 8 + p mod 8.
   function automatic logic [GRAD_W-1:0] grad_of(input logic [PERM_MAXW-1:0] p);
      logic [8:0]  v;
      logic [17:0] q;
      logic [1:0]  r3;
      v  = p[PERM_MAXW-1:3];
      q  = (18'(v) * 18'd171) >> 9;
      r3 = 2'(18'(v) - 18'd3 * q);
      return {r3, p[2:0]};
   endfunction

   function automatic grad_type grad_vec(input logic [GRAD_W-1:0] gi);
      localparam logic signed [GV_W-1:0] GA = 25'sd2189866;
      localparam logic signed [GV_W-1:0] GB = 25'sd6420363;
      localparam logic signed [GV_W-1:0] GC = 25'sd10213322;
      localparam logic signed [GV_W-1:0] GD = 25'sd13310260;
      localparam logic signed [GV_W-1:0] GE = 25'sd15500126;
      localparam logic signed [GV_W-1:0] GF = 25'sd16633685;
      grad_type g;
      case (gi)
         5'd0:    g = '{GA, GF};
         5'd1:    g = '{GB, GE};
         5'd2:    g = '{GC, GD};
         5'd3:    g = '{GD, GC};
         5'd4:    g = '{GE, GB};
         5'd5:    g = '{GF, GA};
         5'd6:    g = '{GF, -GA};
         5'd7:    g = '{GE, -GB};
         5'd8:    g = '{GD, -GC};
         5'd9:    g = '{GC, -GD};
         5'd10:   g = '{GB, -GE};
         5'd11:   g = '{GA, -GF};
         5'd12:   g = '{-GA, -GF};
         5'd13:   g = '{-GB, -GE};
         5'd14:   g = '{-GC, -GD};
         5'd15:   g = '{-GD, -GC};
         5'd16:   g = '{-GE, -GB};
         5'd17:   g = '{-GF, -GA};
         5'd18:   g = '{-GF, GA};
         5'd19:   g = '{-GE, GB};
         5'd20:   g = '{-GD, GC};
         5'd21:   g = '{-GC, GD};
         5'd22:   g = '{-GB, GE};
         5'd23:   g = '{-GA, GF};
         default: g = '0;
      endcase
      return g;
   endfunction

   // Cell and offset of each of the six vertices; the last two follow the triangle.
   function automatic vtx_off_type vtx_off(input logic [2:0] k, input logic upper);
      vtx_off_type o;
      case (k)
         3'd0:    o = '{3'sd0, 3'sd0, 28'sd0, 28'sd0};
         3'd1:    o = '{3'sd1, 3'sd0, -28'sd13231773, 28'sd3545443};
         3'd2:    o = '{3'sd0, 3'sd1, 28'sd3545443, -28'sd13231773};
         3'd3:    o = '{3'sd1, 3'sd1, -28'sd9686330, -28'sd9686330};
         3'd4:    o = upper ? vtx_off_type'{3'sd2, 3'sd1, -28'sd22918103, -28'sd6140887}
                            : vtx_off_type'{-3'sd1, 3'sd0, 28'sd13231773, -28'sd3545443};
         3'd5:    o = upper ? vtx_off_type'{3'sd1, 3'sd2, -28'sd6140887, -28'sd22918103}
                            : vtx_off_type'{3'sd0, -3'sd1, -28'sd3545443, 28'sd13231773};
         default: o = '0;
      endcase
      return o;
   endfunction

endpackage

/* rtl/gn2_if.sv */
// ----------------------------------------------------------------------------
// gn2_if
// Request and response channels of the 2D gradient noise block.
// ----------------------------------------------------------------------------
interface gn2_req_if import gn2_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic                      opcode;
   logic signed [COORD_W-1:0] x_coord;
   logic signed [COORD_W-1:0] z_coord;

   modport source(output valid, opcode, x_coord, z_coord, input ready);
   modport sink(input valid, opcode, x_coord, z_coord, output ready);
endinterface

interface gn2_rsp_if import gn2_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [NOISE_W-1:0] noise_value;
   logic                      rebuild_done;

   modport source(output valid, noise_value, rebuild_done, input ready);
   modport sink(input valid, noise_value, rebuild_done, output ready);
endinterface

/* rtl/gn2_ram.sv */
// ----------------------------------------------------------------------------
// gn2_ram
// Generic memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module gn2_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/gn2_shuffle.sv */
// ----------------------------------------------------------------------------
// gn2_shuffle
// Table rebuild: seeded generator, bit-serial modulo and Fisher-Yates shuffle.
// ----------------------------------------------------------------------------
module gn2_shuffle import gn2_pkg::*; #(
   parameter int TABLE_SIZE = DEF_TABLE_SIZE,
   localparam int IDX_W = $clog2(TABLE_SIZE),
   localparam int PT_W  = IDX_W + GRAD_W
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SEED_W-1:0]  seed,
   input  logic               done_ready,
   output eng_stat_type       stat,
   output logic               ptab_wr_en,
   output logic [IDX_W-1:0]   ptab_wr_addr,
   output logic [PT_W-1:0]    ptab_wr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_ADV, S_LDI, S_MUL, S_MIX, S_DIV, S_RDR, S_WR, S_DONE
   } state_type;

   state_type          state_ff;
   logic [IDX_W-1:0]   i_ff;
   logic [SEED_W-1:0]  st_ff;
   logic [SEED_W-1:0]  mop_ff;
   logic               pass_ff;
   logic [1:0]         ms_ff;
   logic [PROD_W-1:0]  acc_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  prod_in;
   logic [SEED_W-1:0]  dvd_ff;
   logic [IDX_W-1:0]   rem_ff;
   logic [5:0]         cnt_ff;
   logic [IDX_W-1:0]   src_i_ff;

   logic [MUL_W-1:0]   mul_a;
   logic [MUL_W-1:0]   mul_b;
   logic [SEED_W-1:0]  mconst;
   logic [IDX_W:0]     divisor;
   logic [IDX_W:0]     trial;
   logic [SEED_W-1:0]  acc_hi_sum;

   logic               src_wr_en;
   logic [IDX_W-1:0]   src_wr_addr;
   logic [IDX_W-1:0]   src_wr_data;
   logic [IDX_W-1:0]   src_rd_addr;
   logic [IDX_W-1:0]   src_rd_data;

   always_comb begin
      mconst = pass_ff ? MIX_C2 : MIX_C1;
      case (ms_ff)
         2'd1: begin
            mul_a = mop_ff[31:0];
            mul_b = mconst[63:32];
         end
         2'd2: begin
            mul_a = mop_ff[63:32];
            mul_b = mconst[31:0];
         end
         default: begin
            mul_a = mop_ff[31:0];
            mul_b = mconst[31:0];
         end
      endcase
      prod_in    = PROD_W'(mul_a) * PROD_W'(mul_b);
      acc_hi_sum = {acc_ff[63:32] + prod_ff[31:0], acc_ff[31:0]};
      divisor    = {1'b0, i_ff} + (IDX_W+1)'(1);
      trial      = {rem_ff, dvd_ff[SEED_W-1]};
   end

   assign src_wr_en   = (state_ff == S_INIT) || (state_ff == S_WR);
   assign src_wr_addr = (state_ff == S_INIT) ? i_ff : rem_ff;
   assign src_wr_data = (state_ff == S_INIT) ? i_ff : src_i_ff;
   assign src_rd_addr = (state_ff == S_RDR) ? rem_ff : i_ff;

   assign ptab_wr_en   = (state_ff == S_WR);
   assign ptab_wr_addr = i_ff;
   assign ptab_wr_data = {grad_of(PERM_MAXW'(src_rd_data)), src_rd_data};

   assign stat.idle = (state_ff == S_IDLE);
   assign stat.done = (state_ff == S_DONE);

   gn2_ram #(
      .WIDTH (IDX_W),
      .DEPTH (TABLE_SIZE)
   ) u_src_ram (
      .clock   (clock),
      .wr_en   (src_wr_en),
      .wr_addr (src_wr_addr),
      .wr_data (src_wr_data),
      .rd_addr (src_rd_addr),
      .rd_data (src_rd_data)
   );

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  st_ff    <= seed;
                  i_ff     <= '1;
                  state_ff <= S_INIT;
               end
            end
            S_INIT: begin
               i_ff <= i_ff - 1'b1;
               if (i_ff == '0) begin
                  state_ff <= S_ADV;
               end
            end
            S_ADV: begin
               st_ff    <= st_ff + GOLDEN;
               state_ff <= S_LDI;
            end
            S_LDI: begin
               src_i_ff <= src_rd_data;
               mop_ff   <= st_ff ^ (st_ff >> 30);
               pass_ff  <= 1'b0;
               ms_ff    <= 2'd0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               ms_ff <= ms_ff + 2'd1;
               case (ms_ff)
                  2'd0:    acc_ff <= acc_ff;
                  2'd1:    acc_ff <= prod_ff;
                  default: acc_ff <= acc_hi_sum;
               endcase
               if (ms_ff == 2'd3) begin
                  state_ff <= S_MIX;
               end
            end
            S_MIX: begin
               if (!pass_ff) begin
                  mop_ff   <= acc_ff ^ (acc_ff >> 27);
                  pass_ff  <= 1'b1;
                  ms_ff    <= 2'd0;
                  state_ff <= S_MUL;
               end else begin
                  dvd_ff   <= (acc_ff ^ (acc_ff >> 31)) + 64'd31;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               dvd_ff <= dvd_ff << 1;
               cnt_ff <= cnt_ff + 6'd1;
               if (trial >= divisor) begin
                  rem_ff <= IDX_W'(trial - divisor);
               end else begin
                  rem_ff <= IDX_W'(trial);
               end
               if (cnt_ff == 6'd63) begin
                  state_ff <= S_RDR;
               end
            end
            S_RDR: begin
               state_ff <= S_WR;
            end
            S_WR: begin
               i_ff <= i_ff - 1'b1;
               if (i_ff == '0) begin
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_ADV;
               end
            end
            S_DONE: begin
               if (done_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* rtl/gn2_eval.sv */
// ----------------------------------------------------------------------------
// gn2_eval
// Noise evaluation: one shared signed multiplier under a vertex sequencer.
// ----------------------------------------------------------------------------
module gn2_eval import gn2_pkg::*; #(
   parameter int TABLE_SIZE      = DEF_TABLE_SIZE,
   parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
   localparam int IDX_W = $clog2(TABLE_SIZE),
   localparam int PT_W  = IDX_W + GRAD_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [COORD_W-1:0] x_coord,
   input  logic signed [COORD_W-1:0] z_coord,
   input  logic                      done_ready,
   output eng_stat_type              stat,
   output logic signed [NOISE_W-1:0] noise_value,
   output logic [IDX_W-1:0]          ptab_rd_addr,
   input  logic [PT_W-1:0]           ptab_rd_data
);

   localparam int UP_SH = FRAC - COORD_FRAC_BITS;
   localparam int XW    = COORD_W + UP_SH;
   localparam int SW0   = XW + 2;
   localparam int SW    = (SW0 > FRAC + IDX_W) ? SW0 : FRAC + IDX_W + 1;

   typedef enum logic [4:0] {
      E_IDLE, E_SUM, E_SK1, E_SK2, E_SK3, E_SKEW, E_UNSK, E_D,
      V_OFF, V_SQX, V_SQZ, V_ATT, V_CHK, V_PERM, V_GRAD,
      V_EXT1, V_EXT2, V_EXT3, V_CONT, V_ACC, V_NEXT,
      E_SCALE, E_RND, E_DONE
   } state_type;

   state_type                 state_ff;
   logic signed [XW-1:0]      x24_ff;
   logic signed [XW-1:0]      z24_ff;
   logic signed [SW-1:0]      a_ff;
   logic signed [SW-1:0]      s_ff;
   logic signed [SW-1:0]      xs_ff;
   logic signed [SW-1:0]      zs_ff;
   logic                      upper_ff;
   logic signed [D_W-1:0]     dx_ff;
   logic signed [D_W-1:0]     dz_ff;
   logic signed [D_W-1:0]     vdx_ff;
   logic signed [D_W-1:0]     vdz_ff;
   logic [IDX_W-1:0]          cx_ff;
   logic [IDX_W-1:0]          cz_ff;
   logic [2:0]                k_ff;
   logic signed [MUL_W-1:0]   attn_ff;
   grad_type                  gv_ff;
   logic signed [MUL_W-1:0]   a4_ff;
   logic signed [MUL_W-1:0]   ext_ff;
   logic signed [MUL_W-1:0]   sum_ff;
   logic signed [PROD_W-1:0]  acc_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [NOISE_W-1:0] noise_ff;

   logic signed [MUL_W-1:0]   mul_a;
   logic signed [MUL_W-1:0]   mul_b;
   logic [FRAC-1:0]           fx;
   logic [FRAC-1:0]           fz;
   logic [FRAC:0]             fsum;
   logic [IDX_W-1:0]          bx;
   logic [IDX_W-1:0]          bz;
   logic signed [MUL_W-1:0]   prod_q;
   logic signed [PROD_W-1:0]  rnd;
   vtx_off_type               off;

   always_comb begin
      fx     = xs_ff[FRAC-1:0];
      fz     = zs_ff[FRAC-1:0];
      fsum   = {1'b0, fx} + {1'b0, fz};
      bx     = xs_ff[FRAC +: IDX_W];
      bz     = zs_ff[FRAC +: IDX_W];
      prod_q = MUL_W'(prod_ff >>> FRAC);
      off    = vtx_off(k_ff, upper_ff);
      rnd    = (prod_ff + ROUND_BIAS) >>> OUT_SHIFT;
      case (state_ff)
         E_SK1: begin
            mul_a = MUL_W'(a_ff >>> FRAC);
            mul_b = SKEW_Q;
         end
         E_SK2: begin
            mul_a = signed'(MUL_W'(a_ff[FRAC-1:0]));
            mul_b = SKEW_Q;
         end
         E_UNSK: begin
            mul_a = signed'(MUL_W'(fsum));
            mul_b = UNSKEW_Q;
         end
         V_SQX: begin
            mul_a = MUL_W'(vdx_ff);
            mul_b = MUL_W'(vdx_ff);
         end
         V_SQZ: begin
            mul_a = MUL_W'(vdz_ff);
            mul_b = MUL_W'(vdz_ff);
         end
         V_PERM: begin
            mul_a = attn_ff;
            mul_b = attn_ff;
         end
         V_GRAD: begin
            mul_a = prod_q;
            mul_b = prod_q;
         end
         V_EXT1: begin
            mul_a = MUL_W'(gv_ff.gx);
            mul_b = MUL_W'(vdx_ff);
         end
         V_EXT2: begin
            mul_a = MUL_W'(gv_ff.gz);
            mul_b = MUL_W'(vdz_ff);
         end
         V_CONT: begin
            mul_a = a4_ff;
            mul_b = ext_ff;
         end
         E_SCALE: begin
            mul_a = sum_ff;
            mul_b = SCALE_Q;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
      case (state_ff)
         V_PERM:  ptab_rd_addr = ptab_rd_data[IDX_W-1:0] ^ cz_ff;
         default: ptab_rd_addr = cx_ff;
      endcase
   end

   assign stat.idle   = (state_ff == E_IDLE);
   assign stat.done   = (state_ff == E_DONE);
   assign noise_value = noise_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         unique case (state_ff)
            E_IDLE: begin
               if (start) begin
                  x24_ff   <= XW'(x_coord) <<< UP_SH;
                  z24_ff   <= XW'(z_coord) <<< UP_SH;
                  state_ff <= E_SUM;
               end
            end
            E_SUM: begin
               a_ff     <= SW'(x24_ff) + SW'(z24_ff);
               state_ff <= E_SK1;
            end
            E_SK1: begin
               state_ff <= E_SK2;
            end
            E_SK2: begin
               s_ff     <= SW'(prod_ff);
               state_ff <= E_SK3;
            end
            E_SK3: begin
               s_ff     <= s_ff + SW'(prod_ff >>> FRAC);
               state_ff <= E_SKEW;
            end
            E_SKEW: begin
               xs_ff    <= SW'(x24_ff) + s_ff;
               zs_ff    <= SW'(z24_ff) + s_ff;
               state_ff <= E_UNSK;
            end
            E_UNSK: begin
               upper_ff <= fsum > (FRAC+1)'(1 << FRAC);
               state_ff <= E_D;
            end
            E_D: begin
               dx_ff    <= signed'(D_W'(fx)) - D_W'(prod_ff >>> FRAC);
               dz_ff    <= signed'(D_W'(fz)) - D_W'(prod_ff >>> FRAC);
               k_ff     <= '0;
               sum_ff   <= '0;
               state_ff <= V_OFF;
            end
            V_OFF: begin
               vdx_ff   <= dx_ff + off.odx;
               vdz_ff   <= dz_ff + off.odz;
               cx_ff    <= bx + IDX_W'(off.cdx);
               cz_ff    <= bz + IDX_W'(off.cdz);
               state_ff <= V_SQX;
            end
            V_SQX: begin
               state_ff <= V_SQZ;
            end
            V_SQZ: begin
               attn_ff  <= RSQ_Q - prod_q;
               state_ff <= V_ATT;
            end
            V_ATT: begin
               attn_ff  <= attn_ff - prod_q;
               state_ff <= V_CHK;
            end
            V_CHK: begin
               state_ff <= (attn_ff > 32'sd0) ? V_PERM : V_NEXT;
            end
            V_PERM: begin
               state_ff <= V_GRAD;
            end
            V_GRAD: begin
               gv_ff    <= grad_vec(ptab_rd_data[IDX_W +: GRAD_W]);
               state_ff <= V_EXT1;
            end
            V_EXT1: begin
               a4_ff    <= prod_q;
               state_ff <= V_EXT2;
            end
            V_EXT2: begin
               acc_ff   <= prod_ff;
               state_ff <= V_EXT3;
            end
            V_EXT3: begin
               ext_ff   <= MUL_W'((acc_ff + prod_ff) >>> FRAC);
               state_ff <= V_CONT;
            end
            V_CONT: begin
               state_ff <= V_ACC;
            end
            V_ACC: begin
               sum_ff   <= sum_ff + prod_q;
               state_ff <= V_NEXT;
            end
            V_NEXT: begin
               k_ff <= k_ff + 3'd1;
               if (k_ff == 3'd5) begin
                  state_ff <= E_SCALE;
               end else begin
                  state_ff <= V_OFF;
               end
            end
            E_SCALE: begin
               state_ff <= E_RND;
            end
            E_RND: begin
               if (rnd > SAT_HI) begin
                  noise_ff <= NOISE_W'(SAT_HI);
               end else if (rnd < SAT_LO) begin
                  noise_ff <= NOISE_W'(SAT_LO);
               end else begin
                  noise_ff <= NOISE_W'(rnd);
               end
               state_ff <= E_DONE;
            end
            E_DONE: begin
               if (done_ready) begin
                  state_ff <= E_IDLE;
               end
            end
            default: state_ff <= E_IDLE;
         endcase
      end
   end

endmodule

/* rtl/gradient_noise_2d.sv */
// ----------------------------------------------------------------------------
// gradient_noise_2d
// 2D gradient noise over a skewed lattice with a seeded permutation table.
// ----------------------------------------------------------------------------
// An evaluate beat works six vertices through the one shared multiplier,
// plus setup, scaling and rounding; a vertex with no positive attenuation
// skips the gradient steps. A rebuild beat makes one fill sweep of the
// shuffle memory, then per entry a bit-serial modulo and eight multiply steps.
// One beat is worked at a time; a finished result waits in the output register.
// Synchronous reset clears the seed and all control state; the tables are not
// cleared and must be rebuilt before the first evaluation.
module gradient_noise_2d import gn2_pkg::*; #(
   parameter int TABLE_SIZE      = DEF_TABLE_SIZE,
   parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
   input  logic              clock,
   input  logic              reset,
   gn2_req_if.sink           req_ch,
   gn2_rsp_if.source         rsp_ch,
   input  logic              csr_wr_en,
   input  logic [SEED_W-1:0] csr_wr_data
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int PT_W  = IDX_W + GRAD_W;

   logic [SEED_W-1:0]         seed_ff;
   logic                      rsp_valid_ff;
   logic signed [NOISE_W-1:0] noise_ff;
   logic                      rebuild_ff;

   eng_stat_type              shuf_stat;
   eng_stat_type              eval_stat;
   logic                      accept;
   logic                      done_ready;
   logic signed [NOISE_W-1:0] eval_noise;

   logic                      ptab_wr_en;
   logic [IDX_W-1:0]          ptab_wr_addr;
   logic [PT_W-1:0]           ptab_wr_data;
   logic [IDX_W-1:0]          ptab_rd_addr;
   logic [PT_W-1:0]           ptab_rd_data;

   assign req_ch.ready = shuf_stat.idle && eval_stat.idle;
   assign accept       = req_ch.valid && req_ch.ready;
   assign done_ready   = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.noise_value  = noise_ff;
   assign rsp_ch.rebuild_done = rebuild_ff;

   gn2_shuffle #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_gn2_shuffle (
      .clock        (clock),
      .reset        (reset),
      .start        (accept && (req_ch.opcode == OP_REBUILD)),
      .seed         (seed_ff),
      .done_ready   (done_ready),
      .stat         (shuf_stat),
      .ptab_wr_en   (ptab_wr_en),
      .ptab_wr_addr (ptab_wr_addr),
      .ptab_wr_data (ptab_wr_data)
   );

   gn2_eval #(
      .TABLE_SIZE      (TABLE_SIZE),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_gn2_eval (
      .clock        (clock),
      .reset        (reset),
      .start        (accept && (req_ch.opcode == OP_EVALUATE)),
      .x_coord      (req_ch.x_coord),
      .z_coord      (req_ch.z_coord),
      .done_ready   (done_ready),
      .stat         (eval_stat),
      .noise_value  (eval_noise),
      .ptab_rd_addr (ptab_rd_addr),
      .ptab_rd_data (ptab_rd_data)
   );

   gn2_ram #(
      .WIDTH (PT_W),
      .DEPTH (TABLE_SIZE)
   ) u_ptab_ram (
      .clock   (clock),
      .wr_en   (ptab_wr_en),
      .wr_addr (ptab_wr_addr),
      .wr_data (ptab_wr_data),
      .rd_addr (ptab_rd_addr),
      .rd_data (ptab_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            seed_ff <= csr_wr_data;
         end
         if (done_ready && (shuf_stat.done || eval_stat.done)) begin
            rsp_valid_ff <= 1'b1;
            rebuild_ff   <= shuf_stat.done;
            noise_ff     <= shuf_stat.done ? '0 : eval_noise;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

/* rtl/gn2_checker.sv */
// ----------------------------------------------------------------------------
// gn2_checker
// Port-level checks of the 2D gradient noise block, bound to the top level.
// ----------------------------------------------------------------------------
module gn2_checker import gn2_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [NOISE_W-1:0] noise_value,
   input logic                      rebuild_done
);

   // A beat is worked alone, so the block is busy right after it takes one.
   busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while a beat was in work");

   rebuild_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rebuild_done |-> noise_value == '0)
      else $error("rebuild result carries a nonzero noise value");

   no_result_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(noise_value)
         && $stable(rebuild_done))
      else $error("stalled result changed or dropped");

endmodule

bind gradient_noise_2d gn2_checker u_gn2_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .noise_value  (rsp_ch.noise_value),
   .rebuild_done (rsp_ch.rebuild_done)
);

/* tb/gn2_tb_if.sv */
// ----------------------------------------------------------------------------
// gn2_tb_if
// Holds only the time scale setting of the test side; it declares no copies of
// the channel interfaces, which come from the design's own interface file.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

/* tb/tb_gradient_noise_2d.sv */
// ----------------------------------------------------------------------------
// tb_gradient_noise_2d
// Self-checking testbench of the 2D gradient noise block. A queue of pending
// beats feeds a driver with random gaps. The bench predicts the result of
// each accepted beat with its own copy of the permutation tables and the seed.
// A monitor with random stalls checks every response beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_gradient_noise_2d import gn2_pkg::*;;

   typedef struct {
      opcode_type                op;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] z;
   } noise_req_type;

   typedef struct {
      logic signed [NOISE_W-1:0] noise;
      logic                      done;
   } noise_rsp_type;

   localparam int     TSIZE = 2048;
   localparam longint ONE_Q = 64'sd1 <<< 24;
   localparam longint U_Q   = 64'sd3545443;
   localparam longint LIMIT = 4000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [SEED_W-1:0] csr_wr_data = '0;

   gn2_req_if req_ch();
   gn2_rsp_if rsp_ch();

   gradient_noise_2d u_top (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   noise_req_type pending_beats[$];
   noise_rsp_type expected_noise[$];
   bit [10:0]  perm_copy[TSIZE];
   bit [4:0]   grad_copy[TSIZE];
   bit [63:0]  seed_copy = '0;
   int         errors = 0;
   longint     cycles = 0;
   bit         req_taken = 0;
   bit         rsp_taken = 0;
   int         req_gap = 0;
   int         rsp_stall = 0;
   int         hold_off = 0;
   int         rsp_count = 0;
   bit         held = 0;

   function automatic longint fl_mul(longint a, longint b);
      return (a * b) >>> 24;
   endfunction

   function automatic longint mul_wide(longint a, longint k);
      longint hi, lo;
      hi = a >>> 24;
      lo = a - hi * ONE_Q;
      return hi * k + ((lo * k) >>> 24);
   endfunction

   function automatic longint grad_comp(int gi, bit second);
      longint b[6];
      int j;
      longint gx, gz;
      b = '{64'sd2189866, 64'sd6420363, 64'sd10213322,
            64'sd13310260, 64'sd15500126, 64'sd16633685};
      j = gi % 6;
      case (gi / 6)
         0: begin gx = b[j]; gz = b[5-j]; end
         1: begin gx = b[5-j]; gz = -b[j]; end
         2: begin gx = -b[j]; gz = -b[5-j]; end
         default: begin gx = -b[5-j]; gz = b[j]; end
      endcase
      return second ? gz : gx;
   endfunction

   function automatic longint vertex_term(longint cx, longint cz, longint dx, longint dz);
      longint attn, ext, a2, a4;
      bit [10:0] pidx;
      int gi;
      attn = longint'(RSQ_Q) - fl_mul(dx, dx) - fl_mul(dz, dz);
      if (attn <= 0) return 0;
      pidx = perm_copy[cx[10:0]] ^ cz[10:0];
      gi = grad_copy[pidx];
      ext = (grad_comp(gi, 0) * dx + grad_comp(gi, 1) * dz) >>> 24;
      a2 = fl_mul(attn, attn);
      a4 = fl_mul(a2, a2);
      return fl_mul(a4, ext);
   endfunction

   function automatic void shuffle_tables();
      bit [63:0] st, zz, r;
      bit [10:0] src[TSIZE];
      for (int i = 0; i < TSIZE; i++) src[i] = 11'(i);
      st = seed_copy;
      for (int i = TSIZE - 1; i >= 0; i--) begin
         st = st + GOLDEN;
         zz = st;
         zz = (zz ^ (zz >> 30)) * MIX_C1;
         zz = (zz ^ (zz >> 27)) * MIX_C2;
         zz = zz ^ (zz >> 31);
         r = (zz + 64'd31) % 64'(i + 1);
         perm_copy[i] = src[r];
         grad_copy[i] = 5'(src[r] % 24);
         src[r] = src[i];
      end
   endfunction

   function automatic longint noise_at(logic signed [31:0] xin, logic signed [31:0] zin);
      longint x, z, s, xs, zs, bx, bz, fx, fz, t, dx, dz, sum, res;
      x = longint'(xin) * 256;
      z = longint'(zin) * 256;
      s = mul_wide(x + z, longint'(SKEW_Q));
      xs = x + s;
      zs = z + s;
      bx = xs >>> 24;
      bz = zs >>> 24;
      fx = xs & (ONE_Q - 1);
      fz = zs & (ONE_Q - 1);
      t = fl_mul(fx + fz, U_Q);
      dx = fx - t;
      dz = fz - t;
      sum = vertex_term(bx, bz, dx, dz);
      sum += vertex_term(bx + 1, bz, dx - ONE_Q + U_Q, dz + U_Q);
      sum += vertex_term(bx, bz + 1, dx + U_Q, dz - ONE_Q + U_Q);
      sum += vertex_term(bx + 1, bz + 1, dx - ONE_Q + 2 * U_Q, dz - ONE_Q + 2 * U_Q);
      if (fx + fz > ONE_Q) begin
         sum += vertex_term(bx + 2, bz + 1, dx - 2 * ONE_Q + 3 * U_Q, dz - ONE_Q + 3 * U_Q);
         sum += vertex_term(bx + 1, bz + 2, dx - ONE_Q + 3 * U_Q, dz - 2 * ONE_Q + 3 * U_Q);
      end else begin
         sum += vertex_term(bx - 1, bz, dx + ONE_Q - U_Q, dz - U_Q);
         sum += vertex_term(bx, bz - 1, dx - U_Q, dz + ONE_Q - U_Q);
      end
      res = (sum * longint'(SCALE_Q) + (64'sd1 <<< 33)) >>> 34;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return res;
   endfunction

   function automatic logic signed [31:0] rand_coord();
      logic signed [31:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
         2: v = ($signed($urandom_range(0, 63)) - 32) <<< 16;
         default: v = (($signed($urandom_range(0, 255)) - 128) <<< 15)
                      + $signed($urandom_range(0, 3)) - 2;
      endcase
      return v;
   endfunction

   task automatic add_beat(opcode_type op, logic signed [31:0] x, logic signed [31:0] z);
      noise_req_type b;
      b.op = op;
      b.x = x;
      b.z = z;
      pending_beats.push_back(b);
   endtask

   task automatic wait_drained();
      wait (pending_beats.size() == 0 && expected_noise.size() == 0 && !req_ch.valid);
   endtask

   task automatic write_seed(logic [63:0] v);
      wait_drained();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      seed_copy = v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic random_evals(int n);
      for (int i = 0; i < n; i++) add_beat(OP_EVALUATE, rand_coord(), rand_coord());
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_REBUILD;
      req_ch.x_coord = '0;
      req_ch.z_coord = '0;
      rsp_ch.ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_seed(64'd0);
      add_beat(OP_REBUILD, 32'sd0, 32'sd0);
      add_beat(OP_EVALUATE, 32'sd0, 32'sd0);
      add_beat(OP_EVALUATE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      add_beat(OP_EVALUATE, -32'sh8000_0000, -32'sh8000_0000);
      add_beat(OP_EVALUATE, 32'sh7FFF_FFFF, -32'sh8000_0000);
      add_beat(OP_EVALUATE, -32'sh8000_0000, 32'sh7FFF_FFFF);
      add_beat(OP_EVALUATE, -32'sd1, -32'sd1);
      add_beat(OP_EVALUATE, 32'sd1, 32'sd1);
      add_beat(OP_EVALUATE, 32'sh0001_0000, 32'sh0000_0000);
      add_beat(OP_EVALUATE, 32'sh0000_8000, 32'sh0000_8000);
      add_beat(OP_EVALUATE, 32'sh0000_4000, 32'sh0000_4000);
      add_beat(OP_EVALUATE, 32'sh0000_5000, 32'sh0000_5000);
      add_beat(OP_EVALUATE, 32'sh0000_6000, 32'sh0000_2000);
      add_beat(OP_EVALUATE, 32'sh0800_0000, 32'sh0800_0000);
      add_beat(OP_EVALUATE, -32'sh0800_0000, 32'sh07FF_0000);
      add_beat(OP_EVALUATE, 32'sh0003_A000, -32'sh0001_2000);
      add_beat(OP_EVALUATE, 32'sh5555_5555, 32'shAAAA_AAAA);
      add_beat(OP_EVALUATE, 32'shAAAA_AAAA, 32'sh5555_5555);
      random_evals(4);

      write_seed(64'hFFFF_FFFF_FFFF_FFFF);
      add_beat(OP_REBUILD, $urandom, $urandom);
      random_evals(90);
      wait_drained();
      random_evals(100);

      write_seed({$urandom, $urandom});
      add_beat(OP_REBUILD, $urandom, $urandom);
      random_evals(190);

      wait_drained();
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("tb_gradient_noise_2d: clean");
      end else begin
         $display("tb_gradient_noise_2d: errors");
      end
      $finish;
   end

   // The block holds one beat in work and one finished result, so holding
   // off the response side stalls the request side as well.
   always @(posedge clock) begin
      noise_rsp_type e;
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb_gradient_noise_2d: errors");
         $finish;
      end
      req_taken = req_ch.valid && req_ch.ready;
      if (req_taken && !reset) begin
         if (pending_beats[0].op == OP_REBUILD) begin
            shuffle_tables();
            e.noise = '0;
            e.done = 1'b1;
         end else begin
            e.noise = 16'(noise_at(pending_beats[0].x, pending_beats[0].z));
            e.done = 1'b0;
         end
         expected_noise.push_back(e);
         void'(pending_beats.pop_front());
      end
      rsp_taken = rsp_ch.valid && rsp_ch.ready;
      if (rsp_taken && !reset) begin
         rsp_count++;
         if (expected_noise.size() == 0) begin
            $display("%0t: unexpected beat noise %0d done %0b", $realtime,
                     rsp_ch.noise_value, rsp_ch.rebuild_done);
            errors++;
         end else begin
            e = expected_noise.pop_front();
            if (rsp_ch.noise_value !== e.noise) begin
               $display("%0t: noise_value expected %0d actual %0d", $realtime,
                        e.noise, rsp_ch.noise_value);
               errors++;
            end
            if (rsp_ch.rebuild_done !== e.done) begin
               $display("%0t: rebuild_done expected %0b actual %0b", $realtime,
                        e.done, rsp_ch.rebuild_done);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      logic next_valid;
      next_valid = req_ch.valid;
      if (req_taken) begin
         next_valid = 1'b0;
         req_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      end
      if (!next_valid && !reset) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_beats.size() != 0) begin
            next_valid = 1'b1;
            req_ch.opcode <= pending_beats[0].op;
            req_ch.x_coord <= pending_beats[0].x;
            req_ch.z_coord <= pending_beats[0].z;
         end
      end
      req_ch.valid <= next_valid;
   end

   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         if (rsp_count == 60 && !held) begin
            held = 1;
            hold_off = 600;
         end
      end
      if (hold_off > 0) begin
         hold_off--;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !reset;
      end
   end

endmodule

/* filelist.f */
rtl/gn2_pkg.sv
rtl/gn2_if.sv
rtl/gn2_ram.sv
rtl/gn2_shuffle.sv
rtl/gn2_eval.sv
rtl/gradient_noise_2d.sv
rtl/gn2_checker.sv
tb/gn2_tb_if.sv
tb/tb_gradient_noise_2d.sv
